/* hw/rtl/cscn_pkg.sv */
// ----------------------------------------------------------------------------
// cscn_pkg
// Shared types and constants of the color sensor calibrate/normalize block.
// ----------------------------------------------------------------------------
package cscn_pkg;

   localparam int unsigned CountWidth = 16;
   localparam int unsigned SumWidth   = 22;
   localparam int unsigned FillWidth  = 7;
   localparam int unsigned LevelWidth = 8;
   localparam int unsigned LuxWidth   = 21;
   localparam int unsigned StatWidth  = 3;

   // result status codes
   typedef enum logic [StatWidth-1:0] {
      STAT_OK         = 3'd0,
      STAT_WARM_OK    = 3'd1,
      STAT_WARM_SAT   = 3'd2,
      STAT_WARM_DARK  = 3'd3,
      STAT_SATURATED  = 3'd4,
      STAT_TOO_DARK   = 3'd5,
      STAT_RESTARTED  = 3'd6
   } status_type;

   // request payload
   typedef struct packed {
      logic                  command;
      logic [CountWidth-1:0] clear_count;
      logic [CountWidth-1:0] red_count;
      logic [CountWidth-1:0] green_count;
      logic [CountWidth-1:0] blue_count;
   } req_type;

   // response payload
   typedef struct packed {
      status_type            status;
      logic [LevelWidth-1:0] red_level;
      logic [LevelWidth-1:0] green_level;
      logic [LevelWidth-1:0] blue_level;
      logic [LuxWidth-1:0]   lux_sixteenths;
      logic [FillWidth-1:0]  warmup_filled;
   } rsp_type;

   // bit-serial divider control
   typedef struct packed {
      logic start;
   } div_ctl_type;

endpackage

/* hw/rtl/cscn_if.sv */
// ----------------------------------------------------------------------------
// cscn_req_if / cscn_rsp_if
// Valid/ready channels carrying request and response payloads.
// ----------------------------------------------------------------------------
interface cscn_req_if;
   import cscn_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface cscn_rsp_if;
   import cscn_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/cscn_div.sv */
// ----------------------------------------------------------------------------
// cscn_div
// Restoring divider, one quotient bit per cycle, quotient saturated at 255.
// ----------------------------------------------------------------------------
module cscn_div #(
   parameter int unsigned NumWidth = 64,
   parameter int unsigned DenWidth = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cscn_pkg::div_ctl_type               ctl,
   input  logic [NumWidth-1:0]                 numer,
   input  logic [DenWidth-1:0]                 denom,
   output logic                                done,
   output logic [cscn_pkg::LevelWidth-1:0]     quot
);
   import cscn_pkg::*;

   localparam int unsigned CntWidth = $clog2(NumWidth + 1);

   logic [NumWidth-1:0] num_ff, num_in;
   logic [DenWidth:0]   rem_ff, rem_in;
   logic [DenWidth-1:0] den_ff, den_in;
   logic                big_ff, big_in;
   logic [LevelWidth-1:0] q_ff, q_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [DenWidth:0]   trial;
   logic                qbit;

   // one shift-subtract step
   always_comb begin
      trial  = {rem_ff[DenWidth-1:0], num_ff[NumWidth-1]};
      qbit   = (trial >= {1'b0, den_ff});
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      big_in = big_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (ctl.start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         big_in  = 1'b0;
         q_in    = '0;
         cnt_in  = CntWidth'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NumWidth-2:0], 1'b0};
         rem_in = qbit ? trial - {1'b0, den_ff} : trial;
         big_in = big_ff | q_ff[LevelWidth-1];
         q_in   = {q_ff[LevelWidth-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      big_ff <= big_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign done = !busy_ff;
   assign quot = big_ff ? '1 : q_ff;

endmodule

/* hw/rtl/color_sensor_calibrate_normalize.sv */
// ----------------------------------------------------------------------------
// color_sensor_calibrate_normalize
// Warm-up summing of raw color counts, then calibrated levels and lux.
// ----------------------------------------------------------------------------
// flow: restart, warm-up, saturated and too-dark items go straight to output;
//   normal items run three channels in turn on one shared 64-step bit-serial
//   divider, then a bit-serial lux division; white items skip to the lux division
// throughput: one item at a time; next item taken once the result is out
// reset: sums, sample count and control cleared; no clearing pass
module color_sensor_calibrate_normalize #(
   parameter int unsigned WARMUP = 8
) (
   input logic     clock,
   input logic     reset,
   cscn_req_if.sink   req,
   cscn_rsp_if.source rsp
);
   import cscn_pkg::*;

   localparam int unsigned NumW = 64;
   localparam int unsigned DenW = 48;
   localparam int unsigned LuxW = 40;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EVAL, ST_MUL, ST_DIV_START, ST_DIV_WAIT, ST_LUX, ST_OUT
   } state_type;

   state_type            state_ff;
   req_type              item_ff;
   logic [SumWidth-1:0]  sc_ff, sr_ff, sg_ff, sb_ff;
   logic [FillWidth-1:0] taken_ff;
   rsp_type              out_ff;
   logic [1:0]           ch_ff;
   logic [NumW-1:0]      num_ff;
   logic [DenW-1:0]      den_ff;
   logic                 zero_ff;
   logic signed [LuxW-1:0] luxv_ff;
   logic [5:0]           lcnt_ff;
   logic [LuxW+4:0]      lrem_ff;
   logic [LuxW+4:0]      lnum_ff;
   logic [LuxW+4:0]      lq_ff;
   div_ctl_type          dctl;
   logic                 ddone;
   logic [LevelWidth-1:0] dq;

   // derived comparisons
   logic [CountWidth-1:0] x_cur;
   logic [SumWidth-1:0]   sx_cur;
   logic [SumWidth+1:0]   s3;
   logic [27:0]           lw;
   logic                  too_dark;
   logic                  white;
   logic [LuxW+4:0]       ltrial;
   rsp_type               eval_rsp;

   always_comb begin
      unique case (ch_ff)
         2'd0:    begin x_cur = item_ff.red_count;   sx_cur = sr_ff; end
         2'd1:    begin x_cur = item_ff.green_count; sx_cur = sg_ff; end
         default: begin x_cur = item_ff.blue_count;  sx_cur = sb_ff; end
      endcase
      s3     = 24'(sc_ff) * 24'd3;
      lw     = 28'(item_ff.clear_count) * 28'(10 * WARMUP);
      // clear below floor(3S/(10*WARMUP)) means 10*WARMUP*(clear+1) <= 3S
      too_dark = (lw + 28'(10 * WARMUP)) <= 28'(s3);
      white    = 28'(item_ff.clear_count) * 28'(WARMUP) >= 28'(s3) + 28'(sc_ff) * 28'd4;
      ltrial = {lrem_ff[LuxW+3:0], lnum_ff[LuxW+4]};
   end

   // result fields decided at evaluation
   always_comb begin
      eval_rsp = '0;
      if (item_ff.command) begin
         eval_rsp.status = STAT_RESTARTED;
      end else if (taken_ff < FillWidth'(WARMUP)) begin
         eval_rsp.warmup_filled = taken_ff;
         if (item_ff.clear_count == '1) begin
            eval_rsp.status = STAT_WARM_SAT;
         end else if (item_ff.clear_count == '0) begin
            eval_rsp.status = STAT_WARM_DARK;
         end else begin
            eval_rsp.status = STAT_WARM_OK;
            eval_rsp.warmup_filled = taken_ff + 1'b1;
         end
      end else begin
         eval_rsp.warmup_filled = taken_ff;
         if (item_ff.clear_count == '1) begin
            eval_rsp.status = STAT_SATURATED;
         end else if (too_dark) begin
            eval_rsp.status = STAT_TOO_DARK;
         end else begin
            eval_rsp.status = STAT_OK;
            if (white) begin
               eval_rsp.red_level   = '1;
               eval_rsp.green_level = '1;
               eval_rsp.blue_level  = '1;
            end
         end
      end
   end

   assign dctl.start = (state_ff == ST_DIV_START);

   cscn_div #(.NumWidth(NumW), .DenWidth(DenW)) u_div (
      .clock (clock), .reset (reset), .ctl (dctl),
      .numer (num_ff), .denom (den_ff), .done (ddone), .quot (dq)
   );

   assign req.ready = (state_ff == ST_IDLE) && !rsp.valid;
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sc_ff <= '0; sr_ff <= '0; sg_ff <= '0; sb_ff <= '0;
         taken_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  item_ff  <= req.data;
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               out_ff  <= eval_rsp;
               ch_ff   <= 2'd0;
               lcnt_ff <= 6'd0;
               if (item_ff.command) begin
                  sc_ff <= '0; sr_ff <= '0; sg_ff <= '0; sb_ff <= '0;
                  taken_ff <= '0;
                  state_ff <= ST_OUT;
               end else if (taken_ff < FillWidth'(WARMUP)) begin
                  if (item_ff.clear_count != '1 && item_ff.clear_count != '0) begin
                     sc_ff <= sc_ff + SumWidth'(item_ff.clear_count);
                     sr_ff <= sr_ff + SumWidth'(item_ff.red_count);
                     sg_ff <= sg_ff + SumWidth'(item_ff.green_count);
                     sb_ff <= sb_ff + SumWidth'(item_ff.blue_count);
                     taken_ff <= taken_ff + 1'b1;
                  end
                  state_ff <= ST_OUT;
               end else if (item_ff.clear_count == '1 || too_dark) begin
                  state_ff <= ST_OUT;
               end else begin
                  luxv_ff <= LuxW'(40'sd157837 * $signed({1'b0, item_ff.green_count}))
                           - LuxW'(40'sd32466 * $signed({1'b0, item_ff.red_count}))
                           - LuxW'(40'sd73191 * $signed({1'b0, item_ff.blue_count}));
                  state_ff <= white ? ST_LUX : ST_MUL;
               end
            end
            ST_MUL: begin
               // numerator and denominator of one channel
               zero_ff  <= (sx_cur == '0) || (lw <= 28'(s3));
               num_ff   <= NumW'(32'(x_cur) * 32'd255) * NumW'(lw - 28'(s3));
               den_ff   <= DenW'(DenW'(item_ff.clear_count) * DenW'(67)) * DenW'(sx_cur);
               state_ff <= ST_DIV_START;
            end
            ST_DIV_START: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (ddone) begin
                  unique case (ch_ff)
                     2'd0:    out_ff.red_level   <= zero_ff ? '0 : dq;
                     2'd1:    out_ff.green_level <= zero_ff ? '0 : dq;
                     default: out_ff.blue_level  <= zero_ff ? '0 : dq;
                  endcase
                  if (ch_ff == 2'd2) begin
                     state_ff <= ST_LUX;
                     lcnt_ff <= 6'd0;
                  end else begin
                     ch_ff <= ch_ff + 1'b1;
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_LUX: begin
               // bit-serial divide of 16*v by 100000
               if (lcnt_ff == 6'd0) begin
                  if (luxv_ff <= 0) begin
                     out_ff.lux_sixteenths <= '0;
                     state_ff <= ST_OUT;
                  end else begin
                     lnum_ff <= {1'b0, luxv_ff, 4'b0};
                     lrem_ff <= '0;
                     lq_ff   <= '0;
                     lcnt_ff <= 6'd1;
                  end
               end else begin
                  lnum_ff <= {lnum_ff[LuxW+3:0], 1'b0};
                  if (ltrial >= (LuxW + 5)'(100000)) begin
                     lrem_ff <= ltrial - (LuxW + 5)'(100000);
                     lq_ff   <= {lq_ff[LuxW+3:0], 1'b1};
                  end else begin
                     lrem_ff <= ltrial;
                     lq_ff   <= {lq_ff[LuxW+3:0], 1'b0};
                  end
                  if (lcnt_ff == 6'(LuxW + 5)) begin
                     state_ff <= ST_OUT;
                     out_ff.lux_sixteenths <= (ltrial >= (LuxW + 5)'(100000))
                        ? {lq_ff[LuxWidth-2:0], 1'b1} : {lq_ff[LuxWidth-2:0], 1'b0};
                  end else begin
                     lcnt_ff <= lcnt_ff + 1'b1;
                  end
               end
            end
            ST_OUT: begin
               if (rsp.ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
